// File: rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

  typedef logic [6:0] char_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_STATUS
  } state_t;

  localparam logic [1:0] OUTCOME_SCAN       = 2'd0;
  localparam logic [1:0] OUTCOME_CONNECT    = 2'd1;
  localparam logic [1:0] OUTCOME_NO_CARRIER = 2'd2;
  localparam logic [1:0] OUTCOME_IGNORED    = 2'd3;

  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam char_t CHAR_UNDERSCORE  = 7'h5f;
  localparam char_t CHAR_CR          = 7'h0d;
  localparam char_t CHAR_LF          = 7'h0a;
  localparam char_t CHAR_QUERY       = 7'h3f;
  localparam char_t CHAR_STAR        = 7'h2a;
  localparam char_t CHAR_PRINT_FIRST = 7'h20;
  localparam char_t CHAR_PRINT_LAST  = 7'h7e;
  localparam char_t CASE_BIT         = 7'h20;
  localparam char_t CHAR_LOWER_C     = 7'h63;
  localparam char_t CHAR_LOWER_O     = 7'h6f;
  localparam char_t CHAR_LOWER_N     = 7'h6e;

  localparam int WIN_LEN  = 8;
  localparam int HEAD_LEN = 4;

  // "@ okayxk"
  localparam char_t OKAY_PAT [WIN_LEN] = '{7'h40, 7'h20, 7'h6f, 7'h6b,
                                           7'h61, 7'h79, 7'h78, 7'h6b};
  // "NO CARRI"
  localparam char_t FAIL_PAT [WIN_LEN] = '{7'h4e, 7'h4f, 7'h20, 7'h43,
                                           7'h41, 7'h52, 7'h52, 7'h49};

  typedef struct packed {
    logic load;
    logic rd_next;
    logic commit;
    logic sel_status;
  } cbs_cmd_t;

  typedef struct packed {
    logic has_echo;
    logic last_echo;
  } cbs_stat_t;

endpackage

`default_nettype wire

// File: rtl/cbs_byte_if.sv
`default_nettype none

interface cbs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/cbs_item_if.sv
`default_nettype none

interface cbs_item_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [6:0] echo_char;
  logic [1:0] outcome;
  logic       last_item;

  modport source (output valid, output item_kind, output echo_char, output outcome,
                  output last_item, input ready);
  modport sink (input valid, input item_kind, input echo_char, input outcome,
                input last_item, output ready);
endinterface

`default_nettype wire

// File: rtl/cbs_ctrl.sv
`default_nettype none

module cbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rx_valid,
  output logic                   rx_ready,
  output logic                   tx_valid,
  input  wire logic              tx_ready,
  output cbs_pkg::cbs_cmd_t      cmd,
  input  wire cbs_pkg::cbs_stat_t stat
);

  cbs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    rx_ready       = 1'b0;
    tx_valid       = 1'b0;
    unique case (state)
      cbs_pkg::ST_IDLE: begin
        rx_ready = 1'b1;
        if (rx_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.has_echo ? cbs_pkg::ST_ECHO : cbs_pkg::ST_STATUS;
        end
      end
      cbs_pkg::ST_ECHO: begin
        tx_valid = 1'b1;
        if (tx_ready) begin
          if (stat.last_echo) begin
            state_next = cbs_pkg::ST_STATUS;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      cbs_pkg::ST_STATUS: begin
        tx_valid       = 1'b1;
        cmd.sel_status = 1'b1;
        if (tx_ready) begin
          cmd.commit = 1'b1;
          state_next = cbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbs_pkg::ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx_ready && tx_valid))
    else $error("input and output active together");

  a_echo_to_status: assert property (@(posedge clk) disable iff (rst)
    (state == cbs_pkg::ST_ECHO && tx_ready && stat.last_echo)
      |=> state == cbs_pkg::ST_STATUS)
    else $error("status item missing after last echo");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rx_ready)
    else $error("not idle after status item");

endmodule

`default_nettype wire

// File: rtl/cbs_datapath.sv
`default_nettype none

module cbs_datapath #(
  parameter int LINE_CAPACITY = 40
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cbs_pkg::cbs_cmd_t  cmd,
  output cbs_pkg::cbs_stat_t      stat,
  input  wire logic [7:0]         rx_byte,
  output logic                    item_kind,
  output logic [6:0]              echo_char,
  output logic [1:0]              outcome,
  output logic                    last_item
);

  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);

  cbs_pkg::char_t mem [LINE_CAPACITY];
  cbs_pkg::char_t rdata;
  cbs_pkg::char_t head [cbs_pkg::HEAD_LEN];
  cbs_pkg::char_t recent [cbs_pkg::WIN_LEN-1];

  logic [LEN_W-1:0]  line_length;
  logic              armed;
  logic              finished;

  logic [LEN_W-1:0]  echo_cnt;
  logic [ADDR_W-1:0] idx;
  logic              pend_wr;
  logic [ADDR_W-1:0] wr_addr;
  cbs_pkg::char_t    wr_data;
  logic [1:0]        status_outcome;

  cbs_pkg::char_t    c;
  logic              armed_eff;
  logic              is_lf;
  logic              printable;
  logic              full;
  logic              echo_now;
  logic              append;
  logic [ADDR_W-1:0] wr_addr_now;
  logic              con_hit;
  logic              okay_hit;
  logic              fail_hit;
  logic              fin_now;
  logic [LEN_W-1:0]  len_next;
  logic [1:0]        outcome_now;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;

  always_comb begin
    c = rx_byte[6:0];
    if (c == cbs_pkg::CHAR_UNDERSCORE || c == cbs_pkg::CHAR_CR) begin
      c = cbs_pkg::CHAR_LF;
    end
    armed_eff   = armed || c == cbs_pkg::CHAR_QUERY || c == cbs_pkg::CHAR_STAR;
    is_lf       = c == cbs_pkg::CHAR_LF;
    printable   = c >= cbs_pkg::CHAR_PRINT_FIRST && c <= cbs_pkg::CHAR_PRINT_LAST;
    full        = line_length == LEN_W'(LINE_CAPACITY);
    echo_now    = armed_eff && (is_lf || (printable && full));
    append      = armed_eff && !is_lf && printable;
    wr_addr_now = echo_now ? '0 : line_length[ADDR_W-1:0];

    con_hit = head[0] == cbs_pkg::CHAR_STAR &&
              (head[1] | cbs_pkg::CASE_BIT) == cbs_pkg::CHAR_LOWER_C &&
              (head[2] | cbs_pkg::CASE_BIT) == cbs_pkg::CHAR_LOWER_O &&
              (head[3] | cbs_pkg::CASE_BIT) == cbs_pkg::CHAR_LOWER_N;

    okay_hit = c == cbs_pkg::OKAY_PAT[cbs_pkg::WIN_LEN-1];
    fail_hit = c == cbs_pkg::FAIL_PAT[cbs_pkg::WIN_LEN-1];
    for (int i = 0; i < cbs_pkg::WIN_LEN - 1; i++) begin
      okay_hit = okay_hit && recent[i] == cbs_pkg::OKAY_PAT[i];
      fail_hit = fail_hit && recent[i] == cbs_pkg::FAIL_PAT[i];
    end

    // connect on "*con" skips the window check
    if (armed_eff && is_lf && con_hit) begin
      outcome_now = cbs_pkg::OUTCOME_CONNECT;
    end else if (okay_hit) begin
      outcome_now = cbs_pkg::OUTCOME_CONNECT;
    end else if (fail_hit) begin
      outcome_now = cbs_pkg::OUTCOME_NO_CARRIER;
    end else begin
      outcome_now = cbs_pkg::OUTCOME_SCAN;
    end
    fin_now = outcome_now != cbs_pkg::OUTCOME_SCAN;

    if (echo_now) begin
      len_next = append ? LEN_W'(1) : '0;
    end else begin
      len_next = append ? line_length + LEN_W'(1) : line_length;
    end

    stat.has_echo  = !finished && echo_now && line_length != '0;
    stat.last_echo = (LEN_W'(idx) + LEN_W'(1)) == echo_cnt;

    rd_en   = cmd.load || cmd.rd_next;
    rd_addr = cmd.load ? '0 : idx + ADDR_W'(1);
    wr_en   = cmd.commit && pend_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      armed       <= 1'b0;
      finished    <= 1'b0;
      pend_wr     <= 1'b0;
      for (int i = 0; i < cbs_pkg::HEAD_LEN; i++) begin
        head[i] <= '0;
      end
      for (int i = 0; i < cbs_pkg::WIN_LEN - 1; i++) begin
        recent[i] <= '0;
      end
    end else if (cmd.load) begin
      pend_wr <= !finished && append;
      if (!finished) begin
        line_length <= len_next;
        armed       <= armed_eff && !is_lf;
        if (fin_now) begin
          finished <= 1'b1;
        end else begin
          for (int i = 0; i < cbs_pkg::WIN_LEN - 2; i++) begin
            recent[i] <= recent[i+1];
          end
          recent[cbs_pkg::WIN_LEN-2] <= c;
        end
        if (append) begin
          for (int j = 0; j < cbs_pkg::HEAD_LEN; j++) begin
            if (wr_addr_now == ADDR_W'(j)) begin
              head[j] <= c;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      echo_cnt       <= stat.has_echo ? line_length : '0;
      wr_addr        <= wr_addr_now;
      wr_data        <= c;
      status_outcome <= finished ? cbs_pkg::OUTCOME_IGNORED : outcome_now;
      idx            <= '0;
    end else if (cmd.rd_next) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    item_kind = cmd.sel_status ? cbs_pkg::KIND_STATUS : cbs_pkg::KIND_ECHO;
    echo_char = cmd.sel_status ? '0 : rdata;
    outcome   = cmd.sel_status ? status_outcome : cbs_pkg::OUTCOME_SCAN;
    last_item = cmd.sel_status;
  end

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("line store read and write together");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_CAPACITY))
    else $error("line length past capacity");

  a_finish_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag dropped");

  a_echo_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_next |-> (LEN_W'(idx) + LEN_W'(1)) < echo_cnt)
    else $error("echo read past line");

endmodule

`default_nettype wire

// File: rtl/connect_banner_scanner_unit.sv
`default_nettype none

// Connect banner scanner. Each accepted byte produces zero or more echoed
// line characters followed by exactly one status item (last_item set). A byte
// is accepted first, then each echoed character is read from the line store
// and sent, then the status item; a full line echoes LINE_CAPACITY characters.
// Echoed characters go out at one character per cycle while the output is
// ready, a rate set by the single read port of the line store. No new
// byte is taken until the status item of the previous one has been accepted.
// After reset the block is ready at once; no clearing pass is run.
module connect_banner_scanner_unit #(
  parameter int LINE_CAPACITY = 40
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cbs_byte_if.sink    rx,
  cbs_item_if.source  tx
);

  cbs_pkg::cbs_cmd_t  cmd;
  cbs_pkg::cbs_stat_t stat;
  logic               rx_ready;
  logic               tx_valid;

  cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx_ready),
    .tx_valid (tx_valid),
    .tx_ready (tx.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cbs_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .rx_byte   (rx.rx_byte),
    .item_kind (tx.item_kind),
    .echo_char (tx.echo_char),
    .outcome   (tx.outcome),
    .last_item (tx.last_item)
  );

  assign rx.ready = rx_ready;
  assign tx.valid = tx_valid;

endmodule

`default_nettype wire

// File: sim/connect_banner_scanner_checker.sv
`timescale 1ns / 1ps

module connect_banner_scanner_checker
  import cbs_pkg::*;
#(
  parameter int LINE_CAP = 40
) (
  input  logic clk,
  input  logic rst,
  cbs_byte_if  rx,
  cbs_item_if  tx,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic       kind;
    char_t      ch;
    logic [1:0] outcome;
    logic       last;
  } banner_item_t;

  banner_item_t predicted_items[$];

  char_t       line_mem [LINE_CAP];
  int unsigned line_len;
  bit          armed;
  char_t       history [7];
  bit          finished;

  function automatic void queue_item(logic kind, char_t ch, logic [1:0] outcome, logic last);
    banner_item_t it;
    it = '{kind, ch, outcome, last};
    predicted_items.push_back(it);
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < line_len; i++) queue_item(KIND_ECHO, line_mem[i], OUTCOME_SCAN, 1'b0);
    line_len = 0;
  endfunction

  function automatic void scan_byte(logic [7:0] raw);
    char_t c;
    char_t recent [8];
    bit    okay_hit;
    bit    fail_hit;
    if (finished) begin
      queue_item(KIND_STATUS, '0, OUTCOME_IGNORED, 1'b1);
      return;
    end
    c = raw[6:0];
    if (c == CHAR_UNDERSCORE || c == CHAR_CR) c = CHAR_LF;
    if (c == CHAR_QUERY || c == CHAR_STAR) armed = 1'b1;
    if (armed) begin
      if (c == CHAR_LF) begin
        flush_line();
        armed = 1'b0;
        // head test reads the store as is, stale bytes included
        if (line_mem[0] == CHAR_STAR &&
            (line_mem[1] | CASE_BIT) == CHAR_LOWER_C &&
            (line_mem[2] | CASE_BIT) == CHAR_LOWER_O &&
            (line_mem[3] | CASE_BIT) == CHAR_LOWER_N) begin
          finished = 1'b1;
          queue_item(KIND_STATUS, '0, OUTCOME_CONNECT, 1'b1);
          return;
        end
      end else if (c >= CHAR_PRINT_FIRST && c <= CHAR_PRINT_LAST) begin
        if (line_len >= LINE_CAP) flush_line();
        line_mem[line_len] = c;
        line_len++;
      end
    end
    for (int i = 0; i < 7; i++) recent[i] = history[i];
    recent[7] = c;
    okay_hit = 1'b1;
    fail_hit = 1'b1;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (recent[i] != OKAY_PAT[i]) okay_hit = 1'b0;
      if (recent[i] != FAIL_PAT[i]) fail_hit = 1'b0;
    end
    if (okay_hit) begin
      finished = 1'b1;
      queue_item(KIND_STATUS, '0, OUTCOME_CONNECT, 1'b1);
    end else if (fail_hit) begin
      finished = 1'b1;
      queue_item(KIND_STATUS, '0, OUTCOME_NO_CARRIER, 1'b1);
    end else begin
      for (int i = 0; i < 7; i++) history[i] = recent[i + 1];
      queue_item(KIND_STATUS, '0, OUTCOME_SCAN, 1'b1);
    end
  endfunction

  function automatic void compare_item();
    banner_item_t got;
    banner_item_t want;
    got = '{tx.item_kind, tx.echo_char, tx.outcome, tx.last_item};
    if (predicted_items.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected item: kind %0d char %h outcome %0d last %0d",
                 got.kind, got.ch, got.outcome, got.last);
    end else begin
      want = predicted_items.pop_front();
      if (got.kind !== want.kind || got.ch !== want.ch ||
          got.outcome !== want.outcome || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $write("item mismatch: expected kind %0d char %h outcome %0d last %0d",
                 want.kind, want.ch, want.outcome, want.last);
          $display(", got kind %0d char %h outcome %0d last %0d",
                   got.kind, got.ch, got.outcome, got.last);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE_CAP; i++) line_mem[i] = '0;
      for (int i = 0; i < 7; i++) history[i] = '0;
      line_len = 0;
      armed    = 1'b0;
      finished = 1'b0;
      errors   = 0;
      predicted_items.delete();
    end else begin
      if (rx.valid === 1'b1 && rx.ready === 1'b1) scan_byte(rx.rx_byte);
      if (tx.valid === 1'b1 && tx.ready === 1'b1) compare_item();
    end
    pending = predicted_items.size();
  end

endmodule

// File: sim/connect_banner_scanner_unit_test.sv
`timescale 1ns / 1ps

module connect_banner_scanner_unit_test;
  import cbs_pkg::*;

  localparam int LINE_CAP     = 40;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int RX_HOLD      = 300;
  localparam char_t CHAR_UPPER_N = 7'h4e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   sent_count = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  cbs_byte_if rx_ch ();
  cbs_item_if tx_ch ();

  connect_banner_scanner_unit #(.LINE_CAPACITY(LINE_CAP)) uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  connect_banner_scanner_checker #(.LINE_CAP(LINE_CAP)) scan_check (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .tx      (tx_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: one long hold-off early on, a steady stretch, random stalls otherwise
  initial begin
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        tx_ch.ready <= 1'b0;
      end else if (!hold_done && sent_count >= 100) begin
        hold_done = 1'b1;
        hold_left = RX_HOLD;
        tx_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        tx_ch.ready <= 1'b0;
      end else if (sent_count >= 220 && sent_count < 300) begin
        tx_ch.ready <= 1'b1;
      end else begin
        tx_ch.ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic char_t safe_char(int lo, int hi);
    char_t c;
    do c = char_t'($urandom_range(hi, lo));
    while (c == CHAR_LOWER_N || c == CHAR_UPPER_N);
    return c;
  endfunction

  function automatic logic [7:0] on_wire(char_t c);
    return {1'($urandom_range(1)), c};
  endfunction

  task automatic offer_byte(input logic [7:0] b);
    while (!(sent_count >= 220 && sent_count < 300) && $urandom_range(99) < 23) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i]);
  endtask

  function automatic char_t line_end();
    case ($urandom_range(2))
      0: return CHAR_CR;
      1: return CHAR_LF;
      default: return CHAR_UNDERSCORE;
    endcase
  endfunction

  task automatic send_line();
    int len;
    offer_byte(on_wire($urandom_range(1) ? CHAR_QUERY : CHAR_STAR));
    if ($urandom_range(7) == 0) begin
      offer_byte(on_wire(CHAR_STAR));
      send_text($urandom_range(1) ? "co" : "CO");
    end
    len = ($urandom_range(9) < 8) ? $urandom_range(12) : $urandom_range(85, 30);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) offer_byte(on_wire(safe_char(0, 127)));
      else offer_byte(on_wire(safe_char(CHAR_PRINT_FIRST, CHAR_PRINT_LAST)));
    end
    offer_byte(on_wire(line_end()));
  endtask

  // banner with one character changed, sent right after a line end
  task automatic send_near_miss();
    char_t pat [WIN_LEN];
    int    pos;
    char_t alt;
    if ($urandom_range(1)) pat = OKAY_PAT;
    else pat = FAIL_PAT;
    pos = $urandom_range(WIN_LEN - 1);
    do alt = safe_char(0, 127); while (alt == pat[pos]);
    pat[pos] = alt;
    offer_byte(on_wire(CHAR_LF));
    for (int i = 0; i < WIN_LEN; i++) offer_byte(on_wire(pat[i]));
  endtask

  initial begin
    int pick;
    bit paused;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_byte(8'h00);
    offer_byte(8'hff);
    offer_byte(8'h80);
    offer_byte(8'h7e);
    offer_byte(8'h20);
    offer_byte(8'h1f);
    offer_byte({1'b0, CHAR_LF});
    send_text("?Hi");
    offer_byte({1'b1, CHAR_CR});
    send_text("*coX");
    offer_byte({1'b1, CHAR_UNDERSCORE});
    offer_byte({1'b0, CHAR_QUERY});
    offer_byte(8'h7f);
    offer_byte(8'h1f);
    offer_byte({1'b0, CHAR_CR});

    while (sent_count < RANDOM_ITEMS) begin
      if (!paused && sent_count >= 330) begin
        paused = 1'b1;
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 65) send_line();
      else if (pick < 75) send_near_miss();
      else offer_byte(on_wire(safe_char(0, 127)));
    end

    // end the scan one way, then bytes that must be ignored
    offer_byte(on_wire(CHAR_LF));
    case ($urandom_range(3))
      0: begin
        send_text("?abn");
        offer_byte(on_wire(CHAR_CR));
        send_text("*cO");
        offer_byte(on_wire(CHAR_LF));
      end
      1: begin
        send_text("*CONNECT 2400");
        offer_byte(on_wire(CHAR_CR));
      end
      2: send_text("@ okayxk");
      default: send_text("NO CARRIER");
    endcase
    repeat (4) offer_byte(8'($urandom_range(255)));
    rx_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (3 * (LINE_CAP + 2)) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
